@@ rtl/lkv_pkg.sv @@
// shared sizes and constants for the lru key-value cache
`timescale 1ns / 1ps

package lkv_pkg;

	localparam int ENTRIES = 16;
	localparam int KEY_W   = 16;
	localparam int VAL_W   = 31;
	localparam int CAP_W   = 5;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int AGE_W   = IDX_W;
	localparam int CNT_W   = $clog2(ENTRIES + 1);
	localparam int KV_W    = KEY_W + VAL_W;

	localparam logic REQ_GET = 1'b0;
	localparam logic REQ_PUT = 1'b1;

endpackage

@@ rtl/lkv_if.sv @@
// request, response and configuration channels of the lru key-value cache
`timescale 1ns / 1ps

interface lkv_req_if;
	logic                      valid;
	logic                      ready;
	logic                      req_type;
	logic [lkv_pkg::KEY_W-1:0] key;
	logic [lkv_pkg::VAL_W-1:0] value;

	modport source (output valid, req_type, key, value, input ready);
	modport sink (input valid, req_type, key, value, output ready);
endinterface

interface lkv_rsp_if;
	logic                      valid;
	logic                      ready;
	logic                      hit;
	logic [lkv_pkg::VAL_W-1:0] read_value;
	logic                      evicted;
	logic [lkv_pkg::KEY_W-1:0] evicted_key;

	modport source (output valid, hit, read_value, evicted, evicted_key, input ready);
	modport sink (input valid, hit, read_value, evicted, evicted_key, output ready);
endinterface

interface lkv_cfg_if;
	logic                      valid;
	logic                      ready;
	logic [lkv_pkg::CAP_W-1:0] capacity;

	modport source (output valid, capacity, input ready);
	modport sink (input valid, capacity, output ready);
endinterface

@@ rtl/lkv_ram.sv @@
// simple dual-port ram, one write and one registered read port
`timescale 1ns / 1ps

module lkv_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/lru_key_value_cache_top.sv @@
// lru key-value cache: scan and rank-update control around key/data and age rams
// a put or a get hit runs a scan pass and then a rank-update pass; a get miss skips the
//   update pass; one request is in work at a time
// both passes share the single read address of the rams: one pass finds the key and the
//   oldest entry, a second pass rewrites ranks
// a finished response waits in an output register while the next request is taken
// reset clears the valid bits, the entry count and sets capacity to 16; no clearing pass
`timescale 1ns / 1ps

module lru_key_value_cache_top (
	input  logic       clk,
	input  logic       arst_n,
	lkv_req_if.sink    req,
	lkv_rsp_if.source  rsp,
	lkv_cfg_if.sink    cfg
);

	localparam int ENTRIES = lkv_pkg::ENTRIES;
	localparam int KEY_W   = lkv_pkg::KEY_W;
	localparam int VAL_W   = lkv_pkg::VAL_W;
	localparam int CAP_W   = lkv_pkg::CAP_W;
	localparam int IDX_W   = lkv_pkg::IDX_W;
	localparam int AGE_W   = lkv_pkg::AGE_W;
	localparam int CNT_W   = lkv_pkg::CNT_W;
	localparam int KV_W    = lkv_pkg::KV_W;

	localparam logic [ENTRIES-1:0] ONE_HOT0 = ENTRIES'(1);
	localparam logic [IDX_W-1:0]   LAST_IDX = IDX_W'(ENTRIES - 1);
	localparam logic [CAP_W-1:0]   CAP_RESET = CAP_W'(ENTRIES);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_UPDATE,
		ST_FINISH
	} state_t;

	state_t state_q;

	logic [CNT_W-1:0]   issue_q;
	logic               vld_s1;
	logic [IDX_W-1:0]   idx_s1;

	logic               put_q;
	logic [KEY_W-1:0]   key_q;
	logic [VAL_W-1:0]   value_q;
	logic               hit_q;
	logic [IDX_W-1:0]   s_q;
	logic [AGE_W-1:0]   as_q;
	logic [VAL_W-1:0]   rd_q;
	logic [IDX_W-1:0]   old_q;
	logic [KEY_W-1:0]   oldk_q;
	logic [IDX_W-1:0]   nxt_q;
	logic [KEY_W-1:0]   nxtk_q;
	logic               evict_q;
	logic [KEY_W-1:0]   evk_q;
	logic [ENTRIES-1:0] vmask_q;
	logic [IDX_W-1:0]   slot_q;
	logic [ENTRIES-1:0] valid_q;
	logic [CNT_W-1:0]   count_q;
	logic [CAP_W-1:0]   cap_q;

	logic               rsp_valid_q;
	logic               rsp_hit_q;
	logic [VAL_W-1:0]   rsp_value_q;
	logic               rsp_evicted_q;
	logic [KEY_W-1:0]   rsp_evk_q;

	// ram ports
	logic [IDX_W-1:0]   raddr;
	logic [KV_W-1:0]    kv_rdata;
	logic               kv_we;
	logic [KV_W-1:0]    kv_wdata;
	logic [AGE_W-1:0]   age_rdata;
	logic               age_we;
	logic [AGE_W-1:0]   age_wdata;

	logic [KEY_W-1:0]   rd_key;
	logic [VAL_W-1:0]   rd_val;
	logic [CNT_W-1:0]   age_ext;
	logic [CNT_W-1:0]   cnt_m1;
	logic [CNT_W-1:0]   cnt_m2;
	logic [CNT_W-1:0]   cnt_after;
	logic [CNT_W-1:0]   eff_cap;
	logic               evict_c;
	logic [IDX_W-1:0]   victim_c;
	logic [KEY_W-1:0]   victim_key_c;
	logic [ENTRIES-1:0] vmask_c;
	logic [IDX_W-1:0]   slot_c;
	logic               pass_active;
	logic               pass_last;

	lkv_ram #(.WIDTH(KV_W), .DEPTH(ENTRIES)) u_kv_ram (
		.clk   (clk),
		.we    (kv_we),
		.waddr (slot_c),
		.wdata (kv_wdata),
		.raddr (raddr),
		.rdata (kv_rdata)
	);

	lkv_ram #(.WIDTH(AGE_W), .DEPTH(ENTRIES)) u_age_ram (
		.clk   (clk),
		.we    (age_we),
		.waddr (idx_s1),
		.wdata (age_wdata),
		.raddr (raddr),
		.rdata (age_rdata)
	);

	assign req.ready       = (state_q == ST_IDLE);
	assign cfg.ready       = 1'b1;
	assign rsp.valid       = rsp_valid_q;
	assign rsp.hit         = rsp_hit_q;
	assign rsp.read_value  = rsp_value_q;
	assign rsp.evicted     = rsp_evicted_q;
	assign rsp.evicted_key = rsp_evk_q;

	assign raddr       = issue_q[IDX_W-1:0];
	assign pass_active = (state_q == ST_SCAN) || (state_q == ST_UPDATE);
	assign pass_last   = vld_s1 && (idx_s1 == LAST_IDX);

	assign rd_key  = kv_rdata[KV_W-1:VAL_W];
	assign rd_val  = kv_rdata[VAL_W-1:0];
	assign age_ext = CNT_W'(age_rdata);
	assign cnt_m1  = count_q - CNT_W'(1);
	assign cnt_m2  = count_q - CNT_W'(2);

	assign kv_we    = (state_q == ST_DECIDE) && put_q;
	assign kv_wdata = {key_q, value_q};

	// capacity zero acts as one, anything above the entry count saturates
	always_comb begin
		if (cap_q == '0) begin
			eff_cap = CNT_W'(1);
		end else if (32'(cap_q) > ENTRIES) begin
			eff_cap = CNT_W'(ENTRIES);
		end else begin
			eff_cap = CNT_W'(cap_q);
		end
	end

	// ranks form a permutation, so the oldest survivor is rank count-1 unless that was the hit
	always_comb begin
		cnt_after    = count_q - CNT_W'(hit_q);
		evict_c      = put_q && (cnt_after >= eff_cap);
		victim_c     = (hit_q && (old_q == s_q)) ? nxt_q : old_q;
		victim_key_c = (hit_q && (old_q == s_q)) ? nxtk_q : oldk_q;
		vmask_c      = valid_q;
		if (hit_q) begin
			vmask_c = vmask_c & ~(ONE_HOT0 << s_q);
		end
		if (evict_c) begin
			vmask_c = vmask_c & ~(ONE_HOT0 << victim_c);
		end
		slot_c = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (!vmask_c[i]) begin
				slot_c = IDX_W'(i);
			end
		end
	end

	// rank rewrite in the second pass
	always_comb begin
		age_we    = 1'b0;
		age_wdata = '0;
		if (state_q == ST_UPDATE && vld_s1) begin
			if (put_q) begin
				if (idx_s1 == slot_q) begin
					age_we = 1'b1;
				end else if (vmask_q[idx_s1]) begin
					age_we = 1'b1;
					if (hit_q && (age_rdata > as_q)) begin
						age_wdata = age_rdata;
					end else begin
						age_wdata = age_rdata + AGE_W'(1);
					end
				end
			end else begin
				if (idx_s1 == s_q) begin
					age_we = 1'b1;
				end else if (valid_q[idx_s1] && (age_rdata < as_q)) begin
					age_we    = 1'b1;
					age_wdata = age_rdata + AGE_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			issue_q       <= '0;
			vld_s1        <= 1'b0;
			idx_s1        <= '0;
			put_q         <= 1'b0;
			key_q         <= '0;
			value_q       <= '0;
			hit_q         <= 1'b0;
			s_q           <= '0;
			as_q          <= '0;
			rd_q          <= '0;
			old_q         <= '0;
			oldk_q        <= '0;
			nxt_q         <= '0;
			nxtk_q        <= '0;
			evict_q       <= 1'b0;
			evk_q         <= '0;
			vmask_q       <= '0;
			slot_q        <= '0;
			valid_q       <= '0;
			count_q       <= '0;
			cap_q         <= CAP_RESET;
			rsp_valid_q   <= 1'b0;
			rsp_hit_q     <= 1'b0;
			rsp_value_q   <= '0;
			rsp_evicted_q <= 1'b0;
			rsp_evk_q     <= '0;
		end else begin
			if (cfg.valid) begin
				cap_q <= cfg.capacity;
			end

			// the finish state reloads the register itself when it is taken
			if (rsp_valid_q && rsp.ready && (state_q != ST_FINISH)) begin
				rsp_valid_q <= 1'b0;
			end

			// read issue for both passes
			vld_s1 <= pass_active && (32'(issue_q) < ENTRIES);
			idx_s1 <= raddr;
			if (pass_active && (32'(issue_q) < ENTRIES)) begin
				issue_q <= issue_q + CNT_W'(1);
			end

			unique case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						put_q   <= (req.req_type == lkv_pkg::REQ_PUT);
						key_q   <= req.key;
						value_q <= req.value;
						hit_q   <= 1'b0;
						issue_q <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (vld_s1 && valid_q[idx_s1]) begin
						if (rd_key == key_q) begin
							hit_q <= 1'b1;
							s_q   <= idx_s1;
							as_q  <= age_rdata;
							rd_q  <= rd_val;
						end
						if (age_ext == cnt_m1) begin
							old_q  <= idx_s1;
							oldk_q <= rd_key;
						end
						if (age_ext == cnt_m2) begin
							nxt_q  <= idx_s1;
							nxtk_q <= rd_key;
						end
					end
					if (pass_last) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					evict_q <= evict_c;
					evk_q   <= evict_c ? victim_key_c : '0;
					vmask_q <= vmask_c;
					slot_q  <= slot_c;
					issue_q <= '0;
					state_q <= (put_q || hit_q) ? ST_UPDATE : ST_FINISH;
				end
				ST_UPDATE: begin
					if (pass_last) begin
						if (put_q) begin
							valid_q <= vmask_q | (ONE_HOT0 << slot_q);
							count_q <= count_q - CNT_W'(hit_q) - CNT_W'(evict_q)
								+ CNT_W'(1);
						end
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q   <= 1'b1;
						rsp_hit_q     <= hit_q;
						rsp_value_q   <= (hit_q && !put_q) ? rd_q : '0;
						rsp_evicted_q <= evict_q;
						rsp_evk_q     <= evk_q;
						state_q       <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// the fill count always matches the number of valid entries
	a_count_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == int'(count_q))
		else $error("entry count differs from valid bits");

	a_count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= ENTRIES)
		else $error("entry count above entries");

	// a put always leaves at least the inserted entry behind
	a_put_leaves_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH && put_q) |-> count_q != '0)
		else $error("put left the store empty");

	// an eviction is only reported for a put
	a_evict_only_put: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH && evict_q) |-> put_q)
		else $error("eviction on a get request");

endmodule
